@@ sv/sfr_pkg.sv @@
// Shared types and constants for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_LEN_W   = 5;
    localparam int MAX_BYTES   = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_REPL_LENGTH    = 3'd3,
        REG_REPL_LOW       = 3'd4,
        REG_REPL_HIGH      = 3'd5,
        REG_REPLACE_EVERY  = 3'd6
    } sfr_reg_e;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } sfr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } sfr_out_t;

    typedef struct packed {
        logic [CFG_LEN_W-1:0]     pattern_length;
        logic [8*MAX_BYTES-1:0]   pattern_bytes;
        logic [CFG_LEN_W-1:0]     replacement_length;
        logic [8*MAX_BYTES-1:0]   replacement_bytes;
        logic                     replace_every;
    } sfr_cfg_t;

    typedef struct packed {
        logic bare;
        logic ends_string;
    } sfr_res_ctl_t;

endpackage

`default_nettype wire

@@ sv/stream_find_replace_unit.sv @@
// Top level: configuration registers, input stage, match window and result buffer.
// Flow: a request is registered in the input stage, and its results are loaded into the
// result buffer once it is free. Throughput: one request per cycle while each request
// yields at most one result and out_ready stays high; a request that yields more results
// holds the result buffer until all have left (up to the buffer depth). Reset clears
// configuration to defaults, empties the window and result buffer; window bytes remain.
`default_nettype none

module stream_find_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sfr_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sfr_out_t                    out_data
);

    localparam int BUF_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    sfr_cfg_t cfg_reg;

    logic    s1_valid_reg;
    sfr_in_t s1_item_reg;
    logic    buf_free;
    logic    advance;

    logic [BUF_DEPTH-1:0][7:0] res_bytes;
    logic [CNT_W-1:0]          res_count;
    sfr_res_ctl_t              res_ctl;

    logic [BUF_DEPTH-1:0][7:0] buf_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          idx_reg;
    sfr_res_ctl_t              ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                pattern_length:     CFG_LEN_W'(1),
                pattern_bytes:      '0,
                replacement_length: '0,
                replacement_bytes:  '0,
                replace_every:      1'b1
            };
        end
        else if (cfg_we)
        begin
            unique case (sfr_reg_e'(cfg_index))
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[CFG_LEN_W-1:0];
                REG_PATTERN_LOW:    cfg_reg.pattern_bytes[63:0] <= cfg_data;
                REG_PATTERN_HIGH:   cfg_reg.pattern_bytes[127:64] <= cfg_data;
                REG_REPL_LENGTH:    cfg_reg.replacement_length <= cfg_data[CFG_LEN_W-1:0];
                REG_REPL_LOW:       cfg_reg.replacement_bytes[63:0] <= cfg_data;
                REG_REPL_HIGH:      cfg_reg.replacement_bytes[127:64] <= cfg_data;
                REG_REPLACE_EVERY:  cfg_reg.replace_every <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The result buffer can take a new list when empty or when its last result leaves this cycle.
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign advance  = s1_valid_reg && buf_free;
    assign in_ready = !s1_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    sfr_window #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .BUF_DEPTH       (BUF_DEPTH),
        .CNT_W           (CNT_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (advance),
        .item      (s1_item_reg),
        .res_bytes (res_bytes),
        .res_count (res_count),
        .res_ctl   (res_ctl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= res_count;
            idx_reg <= '0;
            ctl_reg <= res_ctl;
        end
        else if (out_valid && out_ready)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            buf_reg <= res_bytes;
        end
    end

    assign out_valid           = cnt_reg != '0;
    assign out_data.out_byte   = ctl_reg.bare ? 8'h00 : buf_reg[idx_reg];
    assign out_data.byte_valid = !ctl_reg.bare;
    assign out_data.last       = ctl_reg.ends_string && (cnt_reg == CNT_W'(1));

    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.last)
        else $error("bare end marker without last");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BUF_DEPTH))
        else $error("result count exceeds buffer depth");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !buf_free |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input stage lost a waiting request");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last && !advance |=> !out_valid)
        else $error("results remain after the end of string");

endmodule

`default_nettype wire

@@ sv/sfr_window.sv @@
// Match window: holds pending bytes, tests the pattern and builds the result list of one request.
`default_nettype none

module sfr_window
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16,
    parameter int BUF_DEPTH       = 16,
    parameter int CNT_W           = 5
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sfr_cfg_t                    cfg,
    input  wire logic                        step,
    input  wire sfr_in_t                     item,
    output logic [BUF_DEPTH-1:0][7:0]        res_bytes,
    output logic [CNT_W-1:0]                 res_count,
    output sfr_res_ctl_t                     res_ctl
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = 6;

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [MAX_PATTERN-1:0][7:0] win_pushed;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic [FILL_W-1:0]           fill_pushed;
    logic                        matched_reg;
    logic                        matched_next;

    logic [CMP_W-1:0] plen_eff;
    logic [CMP_W-1:0] rlen_eff;
    logic             searching;
    logic             at_len;
    logic             over_len;
    logic             eq;
    logic             hit;
    logic             pop;
    logic             eos;

    assign eos = item.end_of_string;

    // Out-of-range lengths are clamped into the supported range.
    always_comb
    begin
        plen_eff = CMP_W'(cfg.pattern_length);
        if (cfg.pattern_length == '0)
        begin
            plen_eff = CMP_W'(1);
        end
        else if (CMP_W'(cfg.pattern_length) > CMP_W'(MAX_PATTERN))
        begin
            plen_eff = CMP_W'(MAX_PATTERN);
        end
        rlen_eff = CMP_W'(cfg.replacement_length);
        if (CMP_W'(cfg.replacement_length) > CMP_W'(MAX_REPLACEMENT))
        begin
            rlen_eff = CMP_W'(MAX_REPLACEMENT);
        end
    end

    always_comb
    begin
        win_pushed = win_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (FILL_W'(i) == fill_reg)
            begin
                win_pushed[i] = item.in_byte;
            end
        end
        fill_pushed = (fill_reg < FILL_W'(MAX_PATTERN)) ? fill_reg + 1'b1 : fill_reg;
    end

    always_comb
    begin
        eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CMP_W'(i) < plen_eff) && (win_pushed[i] != cfg.pattern_bytes[8*i +: 8]))
            begin
                eq = 1'b0;
            end
        end
    end

    assign searching = !(matched_reg && !cfg.replace_every);
    assign at_len    = CMP_W'(fill_pushed) == plen_eff;
    assign over_len  = CMP_W'(fill_pushed) > plen_eff;
    assign hit       = searching && at_len && eq;
    assign pop       = (searching && at_len && !eq) || !searching || over_len;

    // A match sends the replacement; otherwise results are read from the window front.
    always_comb
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            res_bytes[i] = 8'h00;
            if (hit)
            begin
                if (i < MAX_BYTES)
                begin
                    res_bytes[i] = cfg.replacement_bytes[8*i +: 8];
                end
            end
            else if (i < MAX_PATTERN)
            begin
                res_bytes[i] = win_pushed[i];
            end
        end

        if (hit)
        begin
            if (eos && rlen_eff == '0)
            begin
                res_count = CNT_W'(1);
            end
            else
            begin
                res_count = CNT_W'(rlen_eff);
            end
        end
        else if (eos)
        begin
            res_count = CNT_W'(fill_pushed);
        end
        else
        begin
            res_count = pop ? CNT_W'(1) : '0;
        end

        res_ctl.bare        = hit && eos && (rlen_eff == '0);
        res_ctl.ends_string = eos;
    end

    always_comb
    begin
        win_next     = win_pushed;
        fill_next    = fill_pushed;
        matched_next = matched_reg;
        priority if (eos)
        begin
            fill_next    = '0;
            matched_next = 1'b0;
        end
        else if (hit)
        begin
            fill_next    = '0;
            matched_next = 1'b1;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_next[i] = win_pushed[i + 1];
            end
            fill_next = fill_pushed - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            matched_reg <= 1'b0;
        end
        else if (step)
        begin
            fill_reg    <= fill_next;
            matched_reg <= matched_next;
        end
    end

    // The window never stays full between requests: a full window always drains a byte.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(MAX_PATTERN))
        else $error("window fill reached its depth");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_string |=> fill_reg == '0 && !matched_reg)
        else $error("end of string did not clear the window state");

endmodule

`default_nettype wire
